// ===== rtl/adaptive_jitter_buffer_control_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive jitter buffer control
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_JITTER_BUFFER_CONTROL_ASSERT_SVH
`define ADAPTIVE_JITTER_BUFFER_CONTROL_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define AJBC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define AJBC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ajbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive jitter buffer control package
// Field widths, codes and shared types of the slot controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ajbc_pkg;

	// Number of ring slots; the slot and depth widths below are sized for it.
	localparam int SLOT_COUNT = 64;

	localparam int KIND_W     = 1;
	localparam int LEN_W      = 12;
	localparam int DEPTH_W    = 7;
	localparam int SLOT_W     = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 12;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_PUT = 1'b0;
	localparam logic [KIND_W-1:0] KIND_GET = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_DEPTH  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SIZE   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_FLOOR   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_CEILING = 8'd3;

	// Reset values of the configuration registers.
	localparam logic [DEPTH_W-1:0] RST_FIXED_DEPTH  = 7'd0;
	localparam logic [LEN_W-1:0]   RST_FRAME_SIZE   = 12'd256;
	localparam logic [DEPTH_W-1:0] RST_AUTO_FLOOR   = 7'd1;
	localparam logic [DEPTH_W-1:0] RST_AUTO_CEILING = 7'd64;

	// Operations of the shared bin unit.
	localparam logic BIN_OP_INC   = 1'b0;
	localparam logic BIN_OP_HALVE = 1'b1;

	typedef struct packed {
		logic full;
		logic half_a;
		logic half_b;
	} bin_flags_t;

endpackage

`default_nettype wire

// ===== rtl/ajbc_if.sv =====
// ----------------------------------------------------------------------------
// Adaptive jitter buffer control channels
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ajbc_req_if;
	import ajbc_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [LEN_W-1:0]  frame_len;
	modport source (output valid, kind, frame_len, input ready);
	modport sink   (input valid, kind, frame_len, output ready);
endinterface

interface ajbc_rsp_if;
	import ajbc_pkg::*;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [SLOT_W-1:0]  slot;
	logic [DEPTH_W-1:0] fill_level;
	logic [DEPTH_W-1:0] auto_setting;
	modport source (output valid, ok, slot, fill_level, auto_setting, input ready);
	modport sink   (input valid, ok, slot, fill_level, auto_setting, output ready);
endinterface

interface ajbc_cfg_if;
	import ajbc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ajbc_hist_ram.sv =====
// ----------------------------------------------------------------------------
// Phase histogram memory
// One write port, two registered read ports; per-entry valid bits make
// entries that were never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ajbc_hist_ram #(
	parameter int SLOT_COUNT = 64,
	parameter int HW         = 15
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] waddr,
	input  wire logic [HW-1:0]                 wdata,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] raddr_a,
	input  wire logic [$clog2(SLOT_COUNT)-1:0] raddr_b,
	output logic      [HW-1:0]                 rdata_a,
	output logic      [HW-1:0]                 rdata_b
);

	logic [HW-1:0]         mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	logic [HW-1:0]         rd_a_q;
	logic [HW-1:0]         rd_b_q;
	logic                  vld_a_q;
	logic                  vld_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			vld_a_q <= valid_q[raddr_a];
			vld_b_q <= valid_q[raddr_b];
		end
	end

	assign rdata_a = vld_a_q ? rd_a_q : '0;
	assign rdata_b = vld_b_q ? rd_b_q : '0;

endmodule

`default_nettype wire

// ===== rtl/ajbc_bin_unit.sv =====
// ----------------------------------------------------------------------------
// Histogram bin unit
// Shared arithmetic on histogram bins: add one count or halve, plus the
// saturation and peak threshold compares.
// ----------------------------------------------------------------------------
`default_nettype none

module ajbc_bin_unit #(
	parameter int SLOT_COUNT     = 64,
	parameter int HIST_FRAC_BITS = 8,
	parameter int HW             = 15
) (
	input  wire logic               op,
	input  wire logic [HW-1:0]      din_a,
	input  wire logic [HW-1:0]      din_b,
	output logic      [HW-1:0]      res,
	output ajbc_pkg::bin_flags_t    flags
);

	import ajbc_pkg::*;

	localparam logic [HW-1:0] ONE    = HW'(1) << HIST_FRAC_BITS;
	localparam logic [HW-1:0] HALF   = HW'(1) << (HIST_FRAC_BITS - 1);
	localparam logic [HW-1:0] THRESH = HW'(SLOT_COUNT) << HIST_FRAC_BITS;

	always_comb begin
		case (op)
			BIN_OP_INC:   res = din_a + ONE;
			BIN_OP_HALVE: res = din_a >> 1;
			default:      res = din_a;
		endcase
		flags.full   = (res >= THRESH);
		flags.half_a = (din_a >= HALF);
		flags.half_b = (din_b >= HALF);
	end

endmodule

`default_nettype wire

// ===== rtl/ajbc_slot_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring slot controller
// Write and read slot pointers, fill count and arrival/read phases.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_jitter_buffer_control_assert.svh"

module ajbc_slot_ctrl #(
	parameter int SLOT_COUNT = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             fire,
	input  wire logic [ajbc_pkg::KIND_W-1:0]      kind,
	input  wire logic [ajbc_pkg::LEN_W-1:0]       frame_len,
	input  wire logic [ajbc_pkg::LEN_W-1:0]       frame_size,
	input  wire logic [$clog2(SLOT_COUNT+1)-1:0]  depth_limit,
	output logic                                  ok,
	output logic      [$clog2(SLOT_COUNT)-1:0]    slot,
	output logic      [$clog2(SLOT_COUNT+1)-1:0]  held_next,
	output logic      [$clog2(SLOT_COUNT)-1:0]    bin
);

	import ajbc_pkg::*;

	localparam int SW  = $clog2(SLOT_COUNT);
	localparam int HFW = $clog2(SLOT_COUNT + 1);
	localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

	logic [SW-1:0]  wr_slot_q;
	logic [SW-1:0]  rd_slot_q;
	logic [SW-1:0]  arr_ph_q;
	logic [SW-1:0]  rd_ph_q;
	logic [HFW-1:0] held_q;
	logic           len_match;
	logic [SW:0]    bin_wrap;
	logic [SW:0]    occ_wrap;
	logic [SW-1:0]  occ;

	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
		return (v == LAST) ? '0 : v + 1'b1;
	endfunction

	assign len_match = (frame_len == frame_size);
	assign bin_wrap  = (SW+1)'(arr_ph_q) + (SW+1)'(SLOT_COUNT) - (SW+1)'(rd_ph_q);
	assign bin       = (arr_ph_q >= rd_ph_q) ? (arr_ph_q - rd_ph_q) : bin_wrap[SW-1:0];

	always_comb begin
		ok        = 1'b0;
		slot      = '0;
		held_next = held_q;
		case (kind)
			KIND_PUT: begin
				if (held_q < depth_limit && len_match) begin
					ok        = 1'b1;
					slot      = wr_slot_q;
					held_next = held_q + 1'b1;
				end
			end
			KIND_GET: begin
				if (held_q != '0 && len_match) begin
					ok        = 1'b1;
					slot      = rd_slot_q;
					held_next = held_q - 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			arr_ph_q  <= '0;
			rd_ph_q   <= '0;
			held_q    <= '0;
		end else if (fire) begin
			held_q <= held_next;
			if (kind == KIND_PUT) begin
				arr_ph_q <= wrap_inc(arr_ph_q);
				if (ok) begin
					wr_slot_q <= wrap_inc(wr_slot_q);
				end
			end else begin
				rd_ph_q <= wrap_inc(rd_ph_q);
				if (ok) begin
					rd_slot_q <= wrap_inc(rd_slot_q);
				end
			end
		end
	end

	// Distance from read pointer to write pointer around the ring.
	assign occ_wrap = (SW+1)'(wr_slot_q) + (SW+1)'(SLOT_COUNT) - (SW+1)'(rd_slot_q);
	assign occ      = (wr_slot_q >= rd_slot_q) ? (wr_slot_q - rd_slot_q) : occ_wrap[SW-1:0];

	`AJBC_ASSERT_ALWAYS(a_held_range, clk, arst_n, held_q <= HFW'(SLOT_COUNT), "fill count above slot count")
	`AJBC_ASSERT_IMPLIES(a_ptr_full, clk, arst_n, held_q == HFW'(SLOT_COUNT), occ == '0, "full ring with pointers apart")
	`AJBC_ASSERT_IMPLIES(a_ptr_fill, clk, arst_n, held_q != HFW'(SLOT_COUNT), HFW'(occ) == held_q, "pointer distance differs from fill count")

endmodule

`default_nettype wire

// ===== rtl/adaptive_jitter_buffer_control.sv =====
// ----------------------------------------------------------------------------
// Adaptive jitter buffer control
// Slot controller of a frame ring buffer with histogram-driven depth.
// ----------------------------------------------------------------------------
// Each request is a put or a get of one frame. A put is stored when its length
// equals frame_size and the fill level is below the depth limit (fixed_depth, or
// the automatic depth when fixed_depth is 0); a get returns the oldest slot when
// a frame is waiting and its length matches. One response comes back per request.
// The block takes one request at a time: a get goes through the emit step, a put
// first through the hit step, the read-modify-write of the histogram bin through
// the single write port of the histogram memory. When a put drives its bin to
// SLOT_COUNT counts, a rescale follows: a sweep halves every bin through the shared
// bin unit, then a peak search reads both neighbors of the hit bin per cycle on the
// two memory read ports. A finished response waits in an output register, so the
// next request is taken while the previous response is still unclaimed. The
// histogram needs no clearing pass after reset; per-entry valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adaptive_jitter_buffer_control_assert.svh"

module adaptive_jitter_buffer_control #(
	parameter int HIST_FRAC_BITS = 8
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ajbc_req_if.sink    req,
	ajbc_rsp_if.source  rsp,
	ajbc_cfg_if.sink    cfg
);

	import ajbc_pkg::*;

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int HFW   = $clog2(SLOT_COUNT + 1);
	localparam int CW    = (HFW > DEPTH_W) ? HFW : DEPTH_W;
	localparam int HW    = SW + HIST_FRAC_BITS + 1;
	localparam int LIMIT = (SLOT_COUNT - 1) / 2;
	localparam int XW    = $clog2(LIMIT + 1);
	localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_HIT_RD = 3'd1;
	localparam logic [2:0] ST_SWEEP  = 3'd2;
	localparam logic [2:0] ST_SEARCH = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	// Configuration registers.
	logic [DEPTH_W-1:0] fixed_depth_q;
	logic [LEN_W-1:0]   frame_size_q;
	logic [DEPTH_W-1:0] auto_floor_q;
	logic [DEPTH_W-1:0] auto_ceiling_q;
	logic [CW-1:0]      cfg_depth;

	// Sequencer state.
	logic [2:0]     state_q;
	logic [HFW-1:0] auto_depth_q;
	logic [SW-1:0]  hit_q;
	logic [HFW-1:0] idx_q;
	logic           swp_pend_q;
	logic [SW-1:0]  swp_addr_q;
	logic [XW-1:0]  x_q;
	logic [XW-1:0]  px_q;
	logic           pend_q;
	logic [XW-1:0]  width_q;
	logic [SW-1:0]  up_q;
	logic [SW-1:0]  dn_q;

	// Pending response of the request in flight.
	logic           res_ok_q;
	logic [SW-1:0]  res_slot_q;
	logic [HFW-1:0] res_fill_q;

	// Output register.
	logic               rsp_valid_q;
	logic               rsp_ok_q;
	logic [SLOT_W-1:0]  rsp_slot_q;
	logic [DEPTH_W-1:0] rsp_fill_q;
	logic [DEPTH_W-1:0] rsp_auto_q;

	logic           req_fire;
	logic           emit_load;
	logic [HFW-1:0] depth_limit;
	logic           sc_ok;
	logic [SW-1:0]  sc_slot;
	logic [HFW-1:0] sc_held_next;
	logic [SW-1:0]  sc_bin;
	logic           mem_we;
	logic [SW-1:0]  mem_waddr;
	logic [SW-1:0]  mem_raddr_a;
	logic [HW-1:0]  mem_rdata_a;
	logic [HW-1:0]  mem_rdata_b;
	logic           bin_op;
	logic [HW-1:0]  bin_res;
	bin_flags_t     bin_flags;
	logic [CW-1:0]  auto_clamp;

	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] v);
		return (v == LAST) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [SW-1:0] wrap_dec(input logic [SW-1:0] v);
		return (v == '0) ? LAST : v - 1'b1;
	endfunction

	// A request is taken only while the sequencer is idle.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// A nonzero fixed depth overrides the automatic depth.
	assign depth_limit = (fixed_depth_q != '0) ? HFW'(fixed_depth_q) : auto_depth_q;

	ajbc_slot_ctrl #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_slot_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (req_fire),
		.kind        (req.kind),
		.frame_len   (req.frame_len),
		.frame_size  (frame_size_q),
		.depth_limit (depth_limit),
		.ok          (sc_ok),
		.slot        (sc_slot),
		.held_next   (sc_held_next),
		.bin         (sc_bin)
	);

	// Port A serves the hit bin read, the sweep and the upper search side; port B
	// serves the lower search side.
	always_comb begin
		case (state_q)
			ST_SWEEP:  mem_raddr_a = idx_q[SW-1:0];
			ST_SEARCH: mem_raddr_a = up_q;
			default:   mem_raddr_a = sc_bin;
		endcase
	end

	// The hit bin gets one count added; the sweep halves each bin in turn.
	assign bin_op    = (state_q == ST_SWEEP) ? BIN_OP_HALVE : BIN_OP_INC;
	assign mem_we    = (state_q == ST_HIT_RD) || (state_q == ST_SWEEP && swp_pend_q);
	assign mem_waddr = (state_q == ST_HIT_RD) ? hit_q : swp_addr_q;

	ajbc_bin_unit #(
		.SLOT_COUNT     (SLOT_COUNT),
		.HIST_FRAC_BITS (HIST_FRAC_BITS),
		.HW             (HW)
	) u_bin_unit (
		.op    (bin_op),
		.din_a (mem_rdata_a),
		.din_b (mem_rdata_b),
		.res   (bin_res),
		.flags (bin_flags)
	);

	ajbc_hist_ram #(
		.SLOT_COUNT (SLOT_COUNT),
		.HW         (HW)
	) u_hist_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (bin_res),
		.raddr_a (mem_raddr_a),
		.raddr_b (dn_q),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	// Configuration writes; a fixed depth beyond the ring size acts as the ring size.
	assign cfg_depth = (CW'(cfg.data[DEPTH_W-1:0]) > CW'(SLOT_COUNT)) ?
		CW'(SLOT_COUNT) : CW'(cfg.data[DEPTH_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_depth_q  <= RST_FIXED_DEPTH;
			frame_size_q   <= RST_FRAME_SIZE;
			auto_floor_q   <= RST_AUTO_FLOOR;
			auto_ceiling_q <= RST_AUTO_CEILING;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FIXED_DEPTH:  fixed_depth_q  <= DEPTH_W'(cfg_depth);
				REG_FRAME_SIZE:   frame_size_q   <= cfg.data[LEN_W-1:0];
				REG_AUTO_FLOOR:   auto_floor_q   <= cfg.data[DEPTH_W-1:0];
				REG_AUTO_CEILING: auto_ceiling_q <= cfg.data[DEPTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The response leaves once the output register is free or being drained.
	assign emit_load = (state_q == ST_EMIT) && (!rsp_valid_q || rsp.ready);

	// Reported depth: the ceiling caps the automatic depth, and the floor wins
	// when the floor is above the ceiling.
	always_comb begin
		auto_clamp = CW'(auto_depth_q);
		if (auto_clamp > CW'(auto_ceiling_q)) begin
			auto_clamp = CW'(auto_ceiling_q);
		end
		if (auto_clamp < CW'(auto_floor_q)) begin
			auto_clamp = CW'(auto_floor_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			auto_depth_q <= HFW'(SLOT_COUNT);
			hit_q        <= '0;
			idx_q        <= '0;
			swp_pend_q   <= 1'b0;
			swp_addr_q   <= '0;
			x_q          <= '0;
			px_q         <= '0;
			pend_q       <= 1'b0;
			width_q      <= '0;
			up_q         <= '0;
			dn_q         <= '0;
			res_ok_q     <= 1'b0;
			res_slot_q   <= '0;
			res_fill_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						res_ok_q   <= sc_ok;
						res_slot_q <= sc_slot;
						res_fill_q <= sc_held_next;
						hit_q      <= sc_bin;
						state_q    <= (req.kind == KIND_PUT) ? ST_HIT_RD : ST_EMIT;
					end
				end
				ST_HIT_RD: begin
					// The incremented bin is written this cycle; a full bin
					// starts the rescale.
					if (bin_flags.full) begin
						idx_q      <= '0;
						swp_pend_q <= 1'b0;
						state_q    <= ST_SWEEP;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_SWEEP: begin
					// Read one bin per cycle and write it back halved in the cycle after.
					if (idx_q != HFW'(SLOT_COUNT)) begin
						idx_q      <= idx_q + 1'b1;
						swp_addr_q <= idx_q[SW-1:0];
						swp_pend_q <= 1'b1;
					end else begin
						swp_pend_q <= 1'b0;
						x_q        <= XW'(1);
						pend_q     <= 1'b0;
						width_q    <= XW'(1);
						up_q       <= wrap_inc(hit_q);
						dn_q       <= wrap_dec(hit_q);
						state_q    <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					// Issue the two neighbors at distance x, judge them in the next
					// cycle; the widest hit sets the width.
					if (x_q < XW'(LIMIT)) begin
						x_q    <= x_q + 1'b1;
						px_q   <= x_q;
						pend_q <= 1'b1;
						up_q   <= wrap_inc(up_q);
						dn_q   <= wrap_dec(dn_q);
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && (bin_flags.half_a || bin_flags.half_b)) begin
						width_q <= px_q + 1'b1;
					end
					if (x_q >= XW'(LIMIT) && !pend_q) begin
						auto_depth_q <= HFW'({width_q, 1'b0});
						state_q      <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			rsp_ok_q   <= res_ok_q;
			rsp_slot_q <= SLOT_W'(res_slot_q);
			rsp_fill_q <= DEPTH_W'(res_fill_q);
			rsp_auto_q <= DEPTH_W'(auto_clamp);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.slot         = rsp_slot_q;
	assign rsp.fill_level   = rsp_fill_q;
	assign rsp.auto_setting = rsp_auto_q;

	`AJBC_ASSERT_ALWAYS(a_auto_even, clk, arst_n, auto_depth_q[0] == 1'b0 && auto_depth_q != '0, "automatic depth not a nonzero even width")
	`AJBC_ASSERT_IMPLIES(a_rsp_from_emit, clk, arst_n, $rose(rsp_valid_q), $past(state_q == ST_EMIT), "response raised outside the emit step")
	`AJBC_ASSERT_IMPLIES(a_no_req_busy, clk, arst_n, state_q == ST_SWEEP || state_q == ST_SEARCH, !mem_we || state_q == ST_SWEEP, "histogram written during search")

endmodule

`default_nettype wire

// ===== sim/adaptive_jitter_buffer_control_test.sv =====
// ----------------------------------------------------------------------------
// Adaptive jitter buffer control testbench
// Drives put and get requests through the request channel, reprograms the
// depth and frame size registers between phases, and checks every response
// against an in-bench predictor of the slot controller, including the
// histogram rescale and peak-width search that set the automatic depth.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_jitter_buffer_control_test;
	import ajbc_pkg::*;

	localparam int SLOTS         = SLOT_COUNT;
	localparam int FRAC_BITS     = 8;
	localparam int BIN_ONE       = 1 << FRAC_BITS;
	localparam int BIN_HALF      = 1 << (FRAC_BITS - 1);
	localparam int RANDOM_ITEMS  = 900;
	// A put that triggers a rescale keeps the block busy for the sweep plus the
	// search, so the final drain waits longer than such a rescale takes.
	localparam int SETTLE_CYCLES = 150;

	// One response of the slot controller, laid out field by field.
	typedef struct packed {
		logic               ok;
		logic [SLOT_W-1:0]  slot;
		logic [DEPTH_W-1:0] fill_level;
		logic [DEPTH_W-1:0] auto_setting;
	} slot_response_t;

	// Shapes of random traffic used by the random phases.
	typedef enum int {
		TRAFFIC_PACED,
		TRAFFIC_BURST,
		TRAFFIC_FILL,
		TRAFFIC_NOISE
	} traffic_shape_t;

	logic clk = 1'b0;
	logic arst_n;

	ajbc_req_if req_ch ();
	ajbc_rsp_if rsp_ch ();
	ajbc_cfg_if cfg_ch ();

	adaptive_jitter_buffer_control #(
		.HIST_FRAC_BITS (FRAC_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Free-running clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Predictor state. The configuration copy tracks what the block has been
	// told; the ring and histogram copy tracks what it should hold.
	// ------------------------------------------------------------------------
	bit [DEPTH_W-1:0] fixed_depth;
	bit [LEN_W-1:0]   frame_size;
	bit [DEPTH_W-1:0] auto_floor;
	bit [DEPTH_W-1:0] auto_ceiling;

	bit [SLOT_W-1:0]  write_slot;
	bit [SLOT_W-1:0]  read_slot;
	bit [DEPTH_W-1:0] frames_held;
	bit [SLOT_W-1:0]  arrival_phase;
	bit [SLOT_W-1:0]  read_phase;
	bit [DEPTH_W-1:0] auto_depth;
	bit [14:0]        phase_bins [SLOTS];

	// Responses the block still owes, oldest first.
	slot_response_t pending_responses [$];

	int error_count    = 0;
	int requests_sent  = 0;
	int puts_stored    = 0;
	int gets_served    = 0;
	int rescale_count  = 0;
	int register_writes = 0;

	// Largest idle gap of the request side and largest stall of the response
	// side, in cycles. A value of 0 gives a stretch with no idling at all.
	int req_gap_max   = 15;
	int rsp_stall_max = 15;
	int rsp_hold      = 0;

	// Works out the response to one accepted request and queues it. The
	// histogram is updated by every put, stored or not, and a bin that reaches
	// SLOTS whole counts halves all bins and reruns the peak-width search.
	function automatic void predict_request(input logic [KIND_W-1:0] kind,
			input logic [LEN_W-1:0] len);
		slot_response_t   resp;
		bit [DEPTH_W-1:0] limit;
		bit [DEPTH_W-1:0] clamped;
		bit [SLOT_W-1:0]  hit;
		bit [SLOT_W-1:0]  up;
		bit [SLOT_W-1:0]  dn;
		int               width;
		resp = '0;
		if (kind == KIND_PUT) begin
			limit = (fixed_depth != 0) ? fixed_depth : auto_depth;
			if (frames_held < limit && len == frame_size) begin
				resp.ok   = 1'b1;
				resp.slot = write_slot;
				write_slot++;
				frames_held++;
				puts_stored++;
			end
			// Phase difference wraps naturally at the 6-bit width.
			hit = arrival_phase - read_phase;
			arrival_phase++;
			phase_bins[hit] += 15'(BIN_ONE);
			if (phase_bins[hit] >= SLOTS * BIN_ONE) begin
				rescale_count++;
				for (int i = 0; i < SLOTS; i++)
					phase_bins[i] = phase_bins[i] >> 1;
				width = 1;
				for (int x = 1; x < (SLOTS - 1) / 2; x++) begin
					up = hit + SLOT_W'(x);
					dn = hit - SLOT_W'(x);
					if (phase_bins[up] >= BIN_HALF || phase_bins[dn] >= BIN_HALF)
						width = x + 1;
				end
				auto_depth = DEPTH_W'(2 * width);
			end
		end else begin
			read_phase++;
			if (frames_held != 0 && len == frame_size) begin
				resp.ok   = 1'b1;
				resp.slot = read_slot;
				read_slot++;
				frames_held--;
				gets_served++;
			end
		end
		// The ceiling is applied first, so a floor above the ceiling wins.
		clamped = auto_depth;
		if (clamped > auto_ceiling)
			clamped = auto_ceiling;
		if (clamped < auto_floor)
			clamped = auto_floor;
		resp.fill_level   = frames_held;
		resp.auto_setting = clamped;
		pending_responses.push_back(resp);
	endfunction

	// Offers one request after a random idle gap and waits for the handshake.
	// Valid is left high so that a back-to-back request keeps it asserted.
	task automatic send_request(input logic [KIND_W-1:0] kind,
			input logic [LEN_W-1:0] len);
		int gap;
		gap = $urandom_range(req_gap_max, 0);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.kind      <= kind;
		req_ch.frame_len <= len;
		do @(posedge clk); while (!req_ch.ready);
		predict_request(kind, len);
		requests_sent++;
	endtask

	// Drops the request valid and waits until every owed response is back.
	// Each request yields exactly one response, so an empty queue means idle.
	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one configuration register; the caller makes sure the block is idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (index)
			REG_FIXED_DEPTH: begin
				fixed_depth = (data[6:0] > SLOTS) ? DEPTH_W'(SLOTS) : data[6:0];
			end
			REG_FRAME_SIZE: begin
				frame_size = data;
			end
			REG_AUTO_FLOOR: begin
				auto_floor = data[6:0];
			end
			REG_AUTO_CEILING: begin
				auto_ceiling = data[6:0];
			end
			default: begin
			end
		endcase
		register_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly the configured frame size, with near misses, random lengths and
	// the two extremes mixed in so that every length bit toggles.
	function automatic logic [LEN_W-1:0] pick_length();
		int r;
		r = $urandom_range(99, 0);
		if (r < 75)
			return frame_size;
		if (r < 85)
			return frame_size + ((r % 2 == 1) ? 12'd1 : 12'hFFF);
		if (r < 95)
			return LEN_W'($urandom_range(4095, 0));
		return (r % 2 == 1) ? 12'hFFF : 12'h000;
	endfunction

	task automatic send_run(input logic [KIND_W-1:0] kind, input int count);
		repeat (count) send_request(kind, pick_length());
	endtask

	// ------------------------------------------------------------------------
	// Response side: random stalls on ready, and a check of every response
	// against the oldest prediction. Outputs are sampled at the rising edge;
	// ready only changes at the falling edge.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rsp_hold > 0) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold = rsp_hold - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_responses
		slot_response_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_responses.size() == 0) begin
				$error("response arrived with no request outstanding");
				error_count++;
			end else begin
				want = pending_responses.pop_front();
				if (rsp_ch.ok !== want.ok) begin
					$error("ok: expected %0d actual %0d", want.ok, rsp_ch.ok);
					error_count++;
				end
				if (rsp_ch.slot !== want.slot) begin
					$error("slot: expected %0d actual %0d", want.slot, rsp_ch.slot);
					error_count++;
				end
				if (rsp_ch.fill_level !== want.fill_level) begin
					$error("fill_level: expected %0d actual %0d",
						want.fill_level, rsp_ch.fill_level);
					error_count++;
				end
				if (rsp_ch.auto_setting !== want.auto_setting) begin
					$error("auto_setting: expected %0d actual %0d",
						want.auto_setting, rsp_ch.auto_setting);
					error_count++;
				end
			end
			rsp_hold = $urandom_range(rsp_stall_max, 0);
		end
	end

	// ------------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------------

	// Reset configuration: an empty get, a stored put, rejected puts one below the
	// frame size and at the top of the range, a get of the wrong length, a served get.
	task automatic test_reset_defaults();
		send_request(KIND_GET, 12'd256);
		send_request(KIND_PUT, 12'd256);
		send_request(KIND_PUT, 12'd255);
		send_request(KIND_PUT, 12'hFFF);
		send_request(KIND_GET, 12'd0);
		send_request(KIND_GET, 12'd256);
	endtask

	// A small fixed depth refuses the put beyond it. A fixed depth written
	// above the slot count behaves as the slot count; the upper data bits are
	// set too. The last get finds the ring empty.
	task automatic test_fixed_depth();
		wait_idle();
		write_register(REG_FIXED_DEPTH, 12'd2);
		repeat (3) send_request(KIND_PUT, 12'd256);
		wait_idle();
		write_register(REG_FIXED_DEPTH, 12'hFFF);
		send_request(KIND_PUT, 12'd256);
		repeat (4) send_request(KIND_GET, 12'd256);
		wait_idle();
		write_register(REG_FIXED_DEPTH, 12'd0);
	endtask

	// A zero frame size takes only zero-length frames; the largest frame size
	// takes only the largest length.
	task automatic test_frame_size_edges();
		wait_idle();
		write_register(REG_FRAME_SIZE, 12'd0);
		send_request(KIND_PUT, 12'd0);
		send_request(KIND_PUT, 12'd1);
		send_request(KIND_GET, 12'd0);
		wait_idle();
		write_register(REG_FRAME_SIZE, 12'hFFF);
		send_request(KIND_PUT, 12'hFFF);
		send_request(KIND_GET, 12'hFFE);
		send_request(KIND_GET, 12'hFFF);
		wait_idle();
		write_register(REG_FRAME_SIZE, 12'd256);
	endtask

	// Clamping of the reported automatic depth: floor above the ceiling, the
	// widest clamp the register width allows, and both at the extremes.
	task automatic test_auto_clamp();
		wait_idle();
		write_register(REG_AUTO_FLOOR, 12'd40);
		write_register(REG_AUTO_CEILING, 12'd10);
		send_request(KIND_GET, 12'd256);
		wait_idle();
		write_register(REG_AUTO_FLOOR, 12'd0);
		write_register(REG_AUTO_CEILING, 12'd127);
		send_request(KIND_GET, 12'd256);
		wait_idle();
		write_register(REG_AUTO_FLOOR, 12'd64);
		write_register(REG_AUTO_CEILING, 12'd1);
		send_request(KIND_GET, 12'd256);
		wait_idle();
		write_register(REG_AUTO_FLOOR, 12'd1);
		write_register(REG_AUTO_CEILING, 12'd64);
	endtask

	// Strictly paced put/get pairs keep hitting one phase bin, so it fills up
	// and forces a rescale; the automatic depth then limits the ring.
	task automatic test_histogram_rescale();
		repeat (70) begin
			send_request(KIND_PUT, pick_length());
			send_request(KIND_GET, pick_length());
		end
	endtask

	// Random phases, each with fresh register values and its own idling mode.
	// Most traffic is paced arrivals with jitter, which is what concentrates the
	// histogram; bursts and full fills reach the depth limits and wrap the ring,
	// and noise covers arbitrary kinds and lengths.
	task automatic test_random_traffic();
		int               first;
		int               r;
		int               phase_len;
		int               phase_start;
		traffic_shape_t   shape;
		bit [4:0]         high_bits;
		bit [DEPTH_W-1:0] floor_value;
		bit [DEPTH_W-1:0] ceiling_value;
		first = requests_sent;
		while (requests_sent - first < RANDOM_ITEMS) begin
			wait_idle();

			// Depth: automatic most often, then in-range values, the extremes and out-of-range values.
			r = $urandom_range(99, 0);
			high_bits = ($urandom_range(4, 0) == 0) ? 5'($urandom_range(31, 0)) : 5'd0;
			if (r < 45)
				write_register(REG_FIXED_DEPTH, {high_bits, 7'd0});
			else if (r < 60)
				write_register(REG_FIXED_DEPTH, {high_bits, 7'd64});
			else if (r < 70)
				write_register(REG_FIXED_DEPTH, {high_bits, 7'($urandom_range(127, 65))});
			else
				write_register(REG_FIXED_DEPTH, {high_bits, 7'($urandom_range(63, 1))});

			r = $urandom_range(99, 0);
			if (r < 5)
				write_register(REG_FRAME_SIZE, 12'd0);
			else if (r < 10)
				write_register(REG_FRAME_SIZE, 12'hFFF);
			else
				write_register(REG_FRAME_SIZE, 12'($urandom_range(4094, 1)));

			r = $urandom_range(99, 0);
			if (r < 10) begin
				floor_value   = 7'($urandom_range(64, 2));
				ceiling_value = 7'($urandom_range(floor_value - 1, 1));
			end else if (r < 15) begin
				floor_value   = 7'd0;
				ceiling_value = 7'd127;
			end else begin
				floor_value   = 7'($urandom_range(32, 1));
				ceiling_value = 7'($urandom_range(64, floor_value));
			end
			high_bits = ($urandom_range(4, 0) == 0) ? 5'($urandom_range(31, 0)) : 5'd0;
			write_register(REG_AUTO_FLOOR, {high_bits, floor_value});
			write_register(REG_AUTO_CEILING, {~high_bits, ceiling_value});

			req_gap_max   = ($urandom_range(3, 0) == 0) ? 0 : 15;
			rsp_stall_max = ($urandom_range(3, 0) == 0) ? 0 : 15;

			r = $urandom_range(99, 0);
			if (r < 45)
				shape = TRAFFIC_PACED;
			else if (r < 70)
				shape = TRAFFIC_BURST;
			else if (r < 82)
				shape = TRAFFIC_FILL;
			else
				shape = TRAFFIC_NOISE;

			phase_len   = $urandom_range(140, 40);
			phase_start = requests_sent;
			while (requests_sent - phase_start < phase_len) begin
				case (shape)
					TRAFFIC_PACED: begin
						// A put and a get per period; now and then one arrives
						// early or late, which moves the phase by one bin.
						r = $urandom_range(99, 0);
						send_run(KIND_PUT, (r < 10) ? 2 : 1);
						send_run(KIND_GET, (r >= 90) ? 2 : 1);
					end
					TRAFFIC_BURST: begin
						send_run(KIND_PUT, $urandom_range(20, 1));
						send_run(KIND_GET, $urandom_range(20, 1));
					end
					TRAFFIC_FILL: begin
						// Past the largest depth, so the ring fills and wraps.
						send_run(KIND_PUT, 70);
						send_run(KIND_GET, 70);
					end
					default: begin
						send_request(KIND_W'($urandom_range(1, 0)),
							LEN_W'($urandom_range(4095, 0)));
					end
				endcase
			end
		end
		req_gap_max   = 15;
		rsp_stall_max = 15;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		// Every request input known from time zero; reset is held low, then released at a falling edge.
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.kind      = KIND_PUT;
		req_ch.frame_len = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_FIXED_DEPTH;
		cfg_ch.data      = '0;

		fixed_depth   = RST_FIXED_DEPTH;
		frame_size    = RST_FRAME_SIZE;
		auto_floor    = RST_AUTO_FLOOR;
		auto_ceiling  = RST_AUTO_CEILING;
		write_slot    = '0;
		read_slot     = '0;
		frames_held   = '0;
		arrival_phase = '0;
		read_phase    = '0;
		auto_depth    = DEPTH_W'(SLOTS);
		foreach (phase_bins[i])
			phase_bins[i] = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_fixed_depth();
		test_frame_size_edges();
		test_auto_clamp();
		test_histogram_rescale();
		test_random_traffic();

		// Drain: all responses back, then some quiet cycles in which any stray
		// response would still be flagged by the checker.
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests: %0d puts stored, %0d gets served, %0d rescales.",
			requests_sent, puts_stored, gets_served, rescale_count);
		$display("Made %0d register writes; %0d mismatches found.",
			register_writes, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog: a correct run ends far sooner than this.
	initial begin : watchdog
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
